// ===== rtl/clbm_pkg.sv =====
// Shared constants, controller commands and status for the circulation solver.
package clbm_pkg;

  localparam int VTX_W    = 6;
  localparam int NODES    = 64;
  localparam int MAX_VTX  = NODES - 2;
  localparam int EDGES    = 64;
  localparam int EIDX_W   = $clog2(EDGES);
  localparam int CNT_W    = EIDX_W + 1;
  localparam int PAIRS    = EDGES + 2 * NODES;
  localparam int PAIR_W   = $clog2(PAIRS);
  localparam int ARC_W    = PAIR_W + 1;
  localparam int NIDX_W   = $clog2(NODES);
  localparam int QCNT_W   = NIDX_W + 1;
  localparam int DATA_W   = 16;
  localparam int SUM_W    = 22;
  localparam int ENDS_W   = 2 * VTX_W;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SUM,
    OP_RUN_INIT,
    OP_AUX_RD,
    OP_AUX_W0,
    OP_AUX_W1,
    OP_BFS_INIT,
    OP_POP_RD,
    OP_TAKE,
    OP_SCAN,
    OP_MN_INIT,
    OP_PATH_START,
    OP_PATH_EDGE,
    OP_PATH_MIN,
    OP_PATH_UPD,
    OP_AUG_DONE,
    OP_OUT_SINGLE,
    OP_OUT_RD,
    OP_OUT_LD,
    OP_CLEAR
  } clbm_op_t;

  typedef struct packed {
    clbm_op_t op;
  } clbm_cmd_t;

  typedef struct packed {
    logic bad;
    logic item_last;
    logic aux_done;
    logic queue_empty;
    logic scan_last;
    logic sink_found;
    logic origin_found;
    logic single;
    logic res_last;
  } clbm_status_t;

endpackage

// ===== rtl/clbm_ifs.sv =====
// Valid/ready channel interfaces for edge items and result items.
interface clbm_edge_if import clbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VTX_W-1:0]  from_vertex;
  logic [VTX_W-1:0]  to_vertex;
  logic [DATA_W-1:0] low_bound;
  logic [DATA_W-1:0] capacity;
  logic              last;

  modport source(output valid, from_vertex, to_vertex, low_bound, capacity, last,
                 input ready);
  modport sink(input valid, from_vertex, to_vertex, low_bound, capacity, last,
               output ready);
endinterface

interface clbm_res_if import clbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              feasible;
  logic [VTX_W-1:0]  edge_index;
  logic [DATA_W-1:0] edge_flow;
  logic              last_res;

  modport source(output valid, feasible, edge_index, edge_flow, last_res, input ready);
  modport sink(input valid, feasible, edge_index, edge_flow, last_res, output ready);
endinterface

// ===== rtl/circulation_lower_bound_maxflow.sv =====
// Top level: circulation with lower bounds solved by Edmonds-Karp maximum flow.
// Edges arrive one transaction each and are loaded in a load and a sum step. The edge
// marked last starts the run: a check, a source-edge write and a sink-edge write per
// vertex build the source and sink edges, then each breadth-first search scans the
// edge memories one pair per cycle for each dequeued vertex (pairs = edges + 2 *
// vertices), and each augmenting path is walked twice from the sink, once for its
// minimum residual and once for the flow update. The search count is bounded by
// the Edmonds-Karp limit. Each result is read, loaded and then held until it is
// taken, and after the last result the tables are cleared. No new edge is taken
// until the last result of a run has been delivered. The vertex count register
// sits at byte address 0 of the APB port.
module circulation_lower_bound_maxflow import clbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  clbm_edge_if.sink   edges,
  clbm_res_if.source  results
);

  logic [VTX_W-1:0] vtx_count;
  clbm_cmd_t        cmd;
  clbm_status_t     status;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {{(32 - VTX_W){1'b0}}, vtx_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_count <= VTX_W'(1);
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      vtx_count <= pwdata[VTX_W-1:0];
    end
  end

  clbm_ctrl u_ctrl (
    .clk,
    .rst,
    .in_valid  (edges.valid),
    .in_ready  (edges.ready),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .status,
    .cmd
  );

  clbm_dp u_dp (
    .clk,
    .rst,
    .vtx_count,
    .cmd,
    .in_from      (edges.from_vertex),
    .in_to        (edges.to_vertex),
    .in_lower     (edges.low_bound),
    .in_cap       (edges.capacity),
    .in_last      (edges.last),
    .status,
    .res_feasible (results.feasible),
    .res_index    (results.edge_index),
    .res_flow     (results.edge_flow),
    .res_last     (results.last_res)
  );

endmodule

// ===== rtl/clbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module clbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/clbm_dp.sv =====
// Datapath: edge, sum, predecessor and queue memories plus search and flow registers.
module clbm_dp import clbm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [VTX_W-1:0]  vtx_count,
  input  clbm_cmd_t         cmd,
  input  logic [VTX_W-1:0]  in_from,
  input  logic [VTX_W-1:0]  in_to,
  input  logic [DATA_W-1:0] in_lower,
  input  logic [DATA_W-1:0] in_cap,
  input  logic              in_last,
  output clbm_status_t      status,
  output logic              res_feasible,
  output logic [VTX_W-1:0]  res_index,
  output logic [DATA_W-1:0] res_flow,
  output logic              res_last
);

  logic [VTX_W-1:0]  n_v, t_v;
  logic [VTX_W-1:0]  u_r, v_r;
  logic [DATA_W-1:0] lo_r;
  logic              ok_r, room_r, last_r, bad;
  logic [CNT_W-1:0]  loaded, oi;
  logic [SUM_W-1:0]  total_lower, total_flow, mn;
  logic [VTX_W-1:0]  av, cur;
  logic [PAIR_W-1:0] pairs, p, ev_p;
  logic              ev_valid;
  logic [QCNT_W-1:0] head, tail;
  logic [NODES-1:0]  vis, vin, vout;
  logic [ARC_W-1:0]  id_r;

  logic              ok_in, room, from_in_ok, to_in_ok;
  logic [VTX_W-1:0]  from_c, to_c;

  logic              e_we, e_re, f_we, l_we;
  logic [PAIR_W-1:0] e_waddr, f_waddr, e_raddr;
  logic [ENDS_W-1:0] e_wends, ends_rd;
  logic [SUM_W-1:0]  e_wcap, f_wdata, cap_rd, flow_rd;
  logic [DATA_W-1:0] lower_rd;
  logic [VTX_W-1:0]  from_rd, to_rd;

  logic              s_we, s_re;
  logic [VTX_W-1:0]  in_raddr, out_raddr;
  logic [SUM_W-1:0]  in_rd, out_rd, in_old, out_old;

  logic              pr_re;
  logic [VTX_W-1:0]  pr_raddr;
  logic [ARC_W-1:0]  pred_rd;

  logic              q_we;
  logic [NIDX_W-1:0] q_waddr;
  logic [VTX_W-1:0]  q_wdata, q_rd;

  logic              fwd_hit, bwd_hit, hit;
  logic [VTX_W-1:0]  hit_dst, org;
  logic [ARC_W-1:0]  hit_arc;
  logic [SUM_W-1:0]  fwd_res, path_res;
  logic              infeasible;

  assign n_v = (vtx_count > VTX_W'(MAX_VTX)) ? VTX_W'(MAX_VTX) : vtx_count;
  assign t_v = n_v + 1'b1;

  assign from_in_ok = (in_from != '0) && (in_from <= n_v);
  assign to_in_ok   = (in_to != '0) && (in_to <= n_v);
  assign ok_in      = from_in_ok && to_in_ok && (in_lower <= in_cap);
  assign from_c     = from_in_ok ? in_from : VTX_W'(1);
  assign to_c       = to_in_ok ? in_to : VTX_W'(1);
  assign room       = loaded < CNT_W'(EDGES);

  assign from_rd  = ends_rd[ENDS_W-1:VTX_W];
  assign to_rd    = ends_rd[VTX_W-1:0];
  assign fwd_res  = cap_rd - flow_rd;
  assign org      = id_r[0] ? to_rd : from_rd;
  assign path_res = id_r[0] ? flow_rd : fwd_res;

  // Forward arc of a pair is scanned before its backward arc.
  assign fwd_hit = ev_valid && (from_rd == cur) && !vis[to_rd] && (fwd_res != '0)
                   && (to_rd != '0);
  assign bwd_hit = ev_valid && (to_rd == cur) && !vis[from_rd] && (flow_rd != '0)
                   && (from_rd != '0);
  assign hit     = fwd_hit || bwd_hit;
  assign hit_dst = fwd_hit ? to_rd : from_rd;
  assign hit_arc = {ev_p, ~fwd_hit};

  assign in_old  = vin[v_r] ? in_rd : '0;
  assign out_old = vout[u_r] ? out_rd : '0;

  assign infeasible = bad || (total_flow != total_lower);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = pairs;
    e_wends = '0;
    e_wcap  = '0;
    f_we    = 1'b0;
    f_waddr = pairs;
    f_wdata = '0;
    l_we    = 1'b0;
    e_re    = 1'b0;
    e_raddr = p;
    unique case (cmd.op)
      OP_LOAD: begin
        e_we    = room;
        e_waddr = PAIR_W'(loaded[EIDX_W-1:0]);
        e_wends = {from_c, to_c};
        e_wcap  = ok_in ? SUM_W'(in_cap - in_lower) : '0;
        f_we    = room;
        f_waddr = PAIR_W'(loaded[EIDX_W-1:0]);
        l_we    = room;
      end
      OP_AUX_W0: begin
        e_we    = 1'b1;
        e_wends = {VTX_W'(0), av};
        e_wcap  = vin[av] ? in_rd : '0;
        f_we    = 1'b1;
      end
      OP_AUX_W1: begin
        e_we    = 1'b1;
        e_wends = {av, t_v};
        e_wcap  = vout[av] ? out_rd : '0;
        f_we    = 1'b1;
      end
      OP_PATH_UPD: begin
        f_we    = 1'b1;
        f_waddr = id_r[ARC_W-1:1];
        f_wdata = id_r[0] ? (flow_rd - mn) : (flow_rd + mn);
      end
      OP_SCAN: begin
        e_re = 1'b1;
      end
      OP_PATH_EDGE: begin
        e_re    = 1'b1;
        e_raddr = pred_rd[ARC_W-1:1];
      end
      OP_OUT_RD: begin
        e_re    = 1'b1;
        e_raddr = PAIR_W'(oi[EIDX_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    s_we      = (cmd.op == OP_SUM) && room_r && ok_r;
    s_re      = (cmd.op == OP_LOAD) || (cmd.op == OP_AUX_RD);
    in_raddr  = (cmd.op == OP_LOAD) ? in_to : av;
    out_raddr = (cmd.op == OP_LOAD) ? in_from : av;
    pr_re     = (cmd.op == OP_PATH_START) || (cmd.op == OP_PATH_MIN)
                || (cmd.op == OP_PATH_UPD);
    pr_raddr  = (cmd.op == OP_PATH_START) ? t_v : org;
    q_we      = (cmd.op == OP_BFS_INIT) || hit;
    q_waddr   = (cmd.op == OP_BFS_INIT) ? '0 : tail[NIDX_W-1:0];
    q_wdata   = (cmd.op == OP_BFS_INIT) ? '0 : hit_dst;
  end

  clbm_ram #(.WIDTH(ENDS_W), .DEPTH(PAIRS)) u_ends (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wends),
    .re(e_re), .raddr(e_raddr), .rdata(ends_rd));

  clbm_ram #(.WIDTH(SUM_W), .DEPTH(PAIRS)) u_cap (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wcap),
    .re(e_re), .raddr(e_raddr), .rdata(cap_rd));

  clbm_ram #(.WIDTH(SUM_W), .DEPTH(PAIRS)) u_flow (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(flow_rd));

  clbm_ram #(.WIDTH(DATA_W), .DEPTH(EDGES)) u_lower (
    .clk, .we(l_we), .waddr(loaded[EIDX_W-1:0]),
    .wdata(ok_in ? in_lower : '0),
    .re(cmd.op == OP_OUT_RD), .raddr(oi[EIDX_W-1:0]), .rdata(lower_rd));

  clbm_ram #(.WIDTH(SUM_W), .DEPTH(NODES)) u_in_sum (
    .clk, .we(s_we), .waddr(v_r), .wdata(in_old + SUM_W'(lo_r)),
    .re(s_re), .raddr(in_raddr), .rdata(in_rd));

  clbm_ram #(.WIDTH(SUM_W), .DEPTH(NODES)) u_out_sum (
    .clk, .we(s_we), .waddr(u_r), .wdata(out_old + SUM_W'(lo_r)),
    .re(s_re), .raddr(out_raddr), .rdata(out_rd));

  clbm_ram #(.WIDTH(ARC_W), .DEPTH(NODES)) u_pred (
    .clk, .we(hit), .waddr(hit_dst), .wdata(hit_arc),
    .re(pr_re), .raddr(pr_raddr), .rdata(pred_rd));

  clbm_ram #(.WIDTH(VTX_W), .DEPTH(NODES)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(cmd.op == OP_POP_RD), .raddr(head[NIDX_W-1:0]), .rdata(q_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      bad         <= 1'b0;
      loaded      <= '0;
      total_lower <= '0;
      total_flow  <= '0;
      vin         <= '0;
      vout        <= '0;
      vis         <= '0;
      ev_valid    <= 1'b0;
      head        <= '0;
      tail        <= '0;
      oi          <= '0;
      last_r      <= 1'b0;
      res_last    <= 1'b0;
    end else begin
      ev_valid <= (cmd.op == OP_SCAN);
      ev_p     <= p;
      if (hit) begin
        vis[hit_dst] <= 1'b1;
        tail         <= tail + 1'b1;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          u_r    <= in_from;
          v_r    <= in_to;
          lo_r   <= in_lower;
          ok_r   <= ok_in;
          room_r <= room;
          last_r <= in_last;
          if (room && !ok_in) begin
            bad <= 1'b1;
          end
        end
        OP_SUM: begin
          if (room_r) begin
            loaded <= loaded + 1'b1;
          end
          if (room_r && ok_r) begin
            vin[v_r]    <= 1'b1;
            vout[u_r]   <= 1'b1;
            total_lower <= total_lower + SUM_W'(lo_r);
          end
        end
        OP_RUN_INIT: begin
          av    <= VTX_W'(1);
          pairs <= PAIR_W'(loaded);
        end
        OP_AUX_W0: begin
          pairs <= pairs + 1'b1;
        end
        OP_AUX_W1: begin
          pairs <= pairs + 1'b1;
          av    <= av + 1'b1;
        end
        OP_BFS_INIT: begin
          vis  <= '0;
          head <= '0;
          tail <= QCNT_W'(1);
        end
        OP_TAKE: begin
          cur  <= q_rd;
          head <= head + 1'b1;
          p    <= '0;
        end
        OP_SCAN: begin
          p <= p + 1'b1;
        end
        OP_MN_INIT: begin
          mn <= '1;
        end
        OP_PATH_EDGE: begin
          id_r <= pred_rd;
        end
        OP_PATH_MIN: begin
          if (path_res < mn) begin
            mn <= path_res;
          end
        end
        OP_AUG_DONE: begin
          total_flow <= total_flow + mn;
        end
        OP_OUT_SINGLE: begin
          res_feasible <= ~infeasible;
          res_index    <= '0;
          res_flow     <= '0;
          res_last     <= 1'b1;
        end
        OP_OUT_LD: begin
          res_feasible <= 1'b1;
          res_index    <= oi[EIDX_W-1:0];
          res_flow     <= flow_rd[DATA_W-1:0] + lower_rd;
          res_last     <= (oi + 1'b1) == loaded;
          oi           <= oi + 1'b1;
        end
        OP_CLEAR: begin
          bad         <= 1'b0;
          loaded      <= '0;
          total_lower <= '0;
          total_flow  <= '0;
          vin         <= '0;
          vout        <= '0;
          oi          <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status.bad          = bad;
    status.item_last    = last_r;
    status.aux_done     = av > n_v;
    status.queue_empty  = head == tail;
    status.scan_last    = p == (pairs - 1'b1);
    status.sink_found   = vis[t_v];
    status.origin_found = vis[org];
    status.single       = infeasible || (loaded == '0);
    status.res_last     = res_last;
  end

endmodule

// ===== rtl/clbm_ctrl.sv =====
// Controller: sequences loading, augmenting-path search, flow update and result delivery.
module clbm_ctrl import clbm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         res_valid,
  input  logic         res_ready,
  input  clbm_status_t status,
  output clbm_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD_SUM, S_RUN_INIT, S_AUX_CHK, S_AUX_W0, S_AUX_W1,
    S_BFS_INIT, S_POP, S_TAKE, S_SCAN, S_SCAN_END, S_CHECK,
    S_PATH_START, S_PATH_EDGE, S_PATH_STEP, S_AUG_DONE,
    S_FINISH, S_OUT_RD, S_OUT_LD, S_OUT_WAIT, S_CLEAR
  } state_t;

  state_t state, state_next;
  logic   pass2, pass2_next;

  assign in_ready  = state == S_IDLE;
  assign res_valid = state == S_OUT_WAIT;

  always_comb begin
    state_next = state;
    pass2_next = pass2;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_LOAD_SUM;
        end
      end
      S_LOAD_SUM: begin
        cmd.op = OP_SUM;
        if (!status.item_last) state_next = S_IDLE;
        else if (status.bad)   state_next = S_FINISH;
        else                   state_next = S_RUN_INIT;
      end
      S_RUN_INIT: begin
        cmd.op     = OP_RUN_INIT;
        state_next = S_AUX_CHK;
      end
      S_AUX_CHK: begin
        if (status.aux_done) begin
          state_next = S_BFS_INIT;
        end else begin
          cmd.op     = OP_AUX_RD;
          state_next = S_AUX_W0;
        end
      end
      S_AUX_W0: begin
        cmd.op     = OP_AUX_W0;
        state_next = S_AUX_W1;
      end
      S_AUX_W1: begin
        cmd.op     = OP_AUX_W1;
        state_next = S_AUX_CHK;
      end
      S_BFS_INIT: begin
        cmd.op     = OP_BFS_INIT;
        state_next = S_POP;
      end
      S_POP: begin
        if (status.queue_empty) begin
          state_next = S_CHECK;
        end else begin
          cmd.op     = OP_POP_RD;
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.op     = OP_TAKE;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (status.scan_last) state_next = S_SCAN_END;
      end
      S_SCAN_END: begin
        // last pair is evaluated here
        state_next = S_POP;
      end
      S_CHECK: begin
        if (status.sink_found) begin
          cmd.op     = OP_MN_INIT;
          pass2_next = 1'b0;
          state_next = S_PATH_START;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_PATH_START: begin
        cmd.op     = OP_PATH_START;
        state_next = S_PATH_EDGE;
      end
      S_PATH_EDGE: begin
        cmd.op     = OP_PATH_EDGE;
        state_next = S_PATH_STEP;
      end
      S_PATH_STEP: begin
        cmd.op = pass2 ? OP_PATH_UPD : OP_PATH_MIN;
        if (status.origin_found) begin
          state_next = S_PATH_EDGE;
        end else if (pass2) begin
          state_next = S_AUG_DONE;
        end else begin
          pass2_next = 1'b1;
          state_next = S_PATH_START;
        end
      end
      S_AUG_DONE: begin
        cmd.op     = OP_AUG_DONE;
        state_next = S_BFS_INIT;
      end
      S_FINISH: begin
        if (status.single) begin
          cmd.op     = OP_OUT_SINGLE;
          state_next = S_OUT_WAIT;
        end else begin
          cmd.op     = OP_OUT_RD;
          state_next = S_OUT_LD;
        end
      end
      S_OUT_RD: begin
        cmd.op     = OP_OUT_RD;
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.op     = OP_OUT_LD;
        state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (res_ready) state_next = status.res_last ? S_CLEAR : S_OUT_RD;
      end
      S_CLEAR: begin
        cmd.op     = OP_CLEAR;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass2 <= 1'b0;
    end else begin
      state <= state_next;
      pass2 <= pass2_next;
    end
  end

endmodule
